>>> rtl/assert_macros.svh
// Assertion macros for the tick task scheduler.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tts_pkg.sv
// Shared types and constants for the tick task scheduler.
// No dependencies.
`default_nettype none

package tts_pkg;

    localparam int IVAL_W  = 16;
    localparam int PEND_W  = 8;
    localparam int GRANT_W = 3;
    localparam int MODE_W  = 2;

    localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD      = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_TICK,
        OP_DISPATCH,
        OP_ADD
    } op_t;

    typedef struct packed {
        logic exec;
        op_t  op;
    } dp_cmd_t;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> rtl/tts_ctrl.sv
// Handshake controller: owns the result slot and issues datapath commands.
// Depends on tts_pkg.
`default_nettype none

module tts_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               mode,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output tts_pkg::dp_cmd_t              cmd
);
    import tts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg == ST_EMPTY) || out_ready;
        out_valid  = (state_reg == ST_FULL);
        accept     = in_valid && in_ready;
        state_next = state_reg;
        cmd.exec   = accept;
        case (mode)
            MODE_TICK:     cmd.op = OP_TICK;
            MODE_DISPATCH: cmd.op = OP_DISPATCH;
            MODE_ADD:      cmd.op = OP_ADD;
            default:       cmd.op = OP_NOP;
        endcase
        case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!accept && out_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default: state_next = ST_EMPTY;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tts_dp.sv
// Task table datapath: per-entry countdown lanes, grant priority encoder,
// result registers. Depends on tts_pkg.
`default_nettype none

module tts_dp #(
    parameter int TASKS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tts_pkg::dp_cmd_t              cmd,
    input  wire logic [tts_pkg::IVAL_W-1:0]    interval_value,
    output logic                               grant_valid,
    output logic [tts_pkg::GRANT_W-1:0]        grant_index,
    output logic                               add_ok
);
    import tts_pkg::*;

    localparam int CNT_W = $clog2(TASKS + 1);
    localparam int IDX_W = $clog2(TASKS);

    logic [IVAL_W-1:0] reload_reg [TASKS];
    logic [IVAL_W-1:0] cd_reg     [TASKS];
    logic [PEND_W-1:0] pend_reg   [TASKS];
    logic [IVAL_W-1:0] reload_next[TASKS];
    logic [IVAL_W-1:0] cd_next    [TASKS];
    logic [PEND_W-1:0] pend_next  [TASKS];

    logic [CNT_W-1:0]  used_reg;
    logic [TASKS-1:0]  in_use;
    logic [TASKS-1:0]  ready_vec;
    logic              hit;
    logic [IDX_W-1:0]  sel;
    logic              table_full;

    logic               grant_valid_reg;
    logic [GRANT_W-1:0] grant_index_reg;
    logic               add_ok_reg;

    always_comb
    begin
        for (int i = 0; i < TASKS; i++)
        begin
            in_use[i]    = used_reg > CNT_W'(i);
            ready_vec[i] = in_use[i] && (pend_reg[i] != '0);
        end
        hit = |ready_vec;
        sel = '0;
        for (int i = TASKS - 1; i >= 0; i--)
        begin
            if (ready_vec[i])
            begin
                sel = IDX_W'(i);
            end
        end
        table_full = (used_reg == CNT_W'(TASKS));
    end

    for (genvar g = 0; g < TASKS; g++)
    begin : g_lane
        logic [IVAL_W-1:0] dec;
        logic              fire;

        always_comb
        begin
            dec            = cd_reg[g] - 1'b1;
            fire           = 1'b0;
            reload_next[g] = reload_reg[g];
            cd_next[g]     = cd_reg[g];
            pend_next[g]   = pend_reg[g];
            case (cmd.op)
                OP_TICK:
                begin
                    if (in_use[g])
                    begin
                        if (reload_reg[g] != '0)
                        begin
                            if (dec == '0)
                            begin
                                cd_next[g] = reload_reg[g];
                                fire       = 1'b1;
                            end
                            else
                            begin
                                cd_next[g] = dec;
                            end
                        end
                        else if (cd_reg[g] != '0)
                        begin
                            cd_next[g] = dec;
                            fire       = (dec == '0);
                        end
                    end
                    if (fire && (pend_reg[g] != PEND_MAX))
                    begin
                        pend_next[g] = pend_reg[g] + 1'b1;
                    end
                end
                OP_DISPATCH:
                begin
                    if (hit && (sel == IDX_W'(g)))
                    begin
                        pend_next[g] = pend_reg[g] - 1'b1;
                    end
                end
                OP_ADD:
                begin
                    if (!table_full && (used_reg == CNT_W'(g)))
                    begin
                        reload_next[g] = interval_value;
                        cd_next[g]     = (interval_value != '0) ? interval_value
                                                                : IVAL_W'(1);
                        pend_next[g]   = '0;
                    end
                end
                default: ;
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
            begin
                reload_reg[g] <= reload_next[g];
                cd_reg[g]     <= cd_next[g];
                pend_reg[g]   <= pend_next[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.exec && (cmd.op == OP_ADD) && !table_full)
        begin
            used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            grant_valid_reg <= (cmd.op == OP_DISPATCH) && hit;
            grant_index_reg <= ((cmd.op == OP_DISPATCH) && hit) ? GRANT_W'(sel) : '0;
            add_ok_reg      <= (cmd.op == OP_ADD) && !table_full;
        end
    end

    assign grant_valid = grant_valid_reg;
    assign grant_index = grant_index_reg;
    assign add_ok      = add_ok_reg;

endmodule

`default_nettype wire

>>> rtl/tick_task_scheduler.sv
// Tick task scheduler top level: controller plus task table datapath.
// Results are registered: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the single result register sets the pace,
// and a new item is taken in the cycle the held result is taken.
// Reset: asynchronous, clears the task count and the result slot; table
// entries are written when a task is added.
`default_nettype none
`include "assert_macros.svh"

module tick_task_scheduler #(
    parameter int TASKS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tts_pkg::MODE_W-1:0]    mode,
    input  wire logic [tts_pkg::IVAL_W-1:0]    interval_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               grant_valid,
    output logic [tts_pkg::GRANT_W-1:0]        grant_index,
    output logic                               add_ok
);
    import tts_pkg::*;

    dp_cmd_t cmd;

    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tts_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .interval_value (interval_value),
        .grant_valid    (grant_valid),
        .grant_index    (grant_index),
        .add_ok         (add_ok)
    );

    `TTS_ASSERT_NXT(a_result_follows, in_valid && in_ready, out_valid, "no result after item")
    `TTS_ASSERT_IMP(a_grant_add_excl, out_valid && grant_valid, !add_ok, "grant with add_ok")
    `TTS_ASSERT_IMP(a_idle_index_zero, out_valid && !grant_valid, grant_index == '0, "stray index")
    `TTS_ASSERT_IMP(a_exec_on_accept, cmd.exec, in_valid && in_ready, "datapath ran without item")

endmodule

`default_nettype wire

>>> tb/tb_tick_task_scheduler.sv
// Self-checking testbench for tick_task_scheduler: directed table, then random items.
// Uses a cycle-free task table predictor. Depends on tts_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_tick_task_scheduler;

    import tts_pkg::*;

    localparam int TASK_SLOTS = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic                grant_valid;
        logic [GRANT_W-1:0]  grant_index;
        logic                add_ok;
    } sched_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IVAL_W-1:0]  ival;
        logic               typed;
        sched_result_t      res;
    } stim_row_t;

    localparam sched_result_t R_ZERO = '{1'b0, 3'd0, 1'b0};
    localparam sched_result_t R_ADDED = '{1'b0, 3'd0, 1'b1};

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_DISPATCH, 16'h0000, 1'b1, R_ZERO},
        '{MODE_TICK,     16'hFFFF, 1'b1, R_ZERO},
        '{MODE_UNUSED,   16'hFFFF, 1'b1, R_ZERO},
        '{MODE_ADD,      16'h0000, 1'b1, R_ADDED},
        '{MODE_ADD,      16'hFFFF, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0001, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0002, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0003, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0007, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0100, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h0001, 1'b1, R_ADDED},
        '{MODE_ADD,      16'h8000, 1'b1, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b1, R_ZERO},
        '{MODE_UNUSED,   16'h5555, 1'b1, R_ZERO},
        '{MODE_TICK,     16'h0000, 1'b1, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_TICK,     16'h0000, 1'b1, R_ZERO},
        '{MODE_TICK,     16'h0000, 1'b1, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_DISPATCH, 16'h0000, 1'b0, R_ZERO},
        '{MODE_ADD,      16'hAAAA, 1'b1, R_ZERO}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode;
    logic [IVAL_W-1:0]    interval_value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 grant_valid;
    logic [GRANT_W-1:0]   grant_index;
    logic                 add_ok;

    logic [IVAL_W-1:0]    reload_q  [TASK_SLOTS];
    logic [IVAL_W-1:0]    count_q   [TASK_SLOTS];
    logic [PEND_W-1:0]    pending_q [TASK_SLOTS];
    int unsigned          used_slots;

    sched_result_t        expected_results [$];
    int                   err_count;
    int                   items_sent;
    int                   results_seen;

    tick_task_scheduler #(.TASKS(TASK_SLOTS)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .interval_value (interval_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .grant_valid    (grant_valid),
        .grant_index    (grant_index),
        .add_ok         (add_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic sched_result_t sched_step(input logic [MODE_W-1:0] m,
                                                 input logic [IVAL_W-1:0] v);
        sched_result_t r;
        bit            fire;
        int            i;
        r = R_ZERO;
        case (m)
            MODE_TICK:
            begin
                for (i = 0; i < int'(used_slots); i++)
                begin
                    fire = 1'b0;
                    if (reload_q[i] != '0)
                    begin
                        count_q[i] = count_q[i] - 1'b1;
                        if (count_q[i] == '0)
                        begin
                            count_q[i] = reload_q[i];
                            fire = 1'b1;
                        end
                    end
                    else if (count_q[i] != '0)
                    begin
                        count_q[i] = count_q[i] - 1'b1;
                        fire = (count_q[i] == '0);
                    end
                    if (fire && pending_q[i] != PEND_MAX)
                        pending_q[i] = pending_q[i] + 1'b1;
                end
            end
            MODE_DISPATCH:
            begin
                for (i = 0; i < int'(used_slots); i++)
                begin
                    if (!r.grant_valid && pending_q[i] != '0)
                    begin
                        pending_q[i] = pending_q[i] - 1'b1;
                        r.grant_valid = 1'b1;
                        r.grant_index = i[GRANT_W-1:0];
                    end
                end
            end
            MODE_ADD:
            begin
                if (used_slots < TASK_SLOTS)
                begin
                    reload_q[used_slots]  = v;
                    count_q[used_slots]   = (v != '0) ? v : 16'd1;
                    pending_q[used_slots] = '0;
                    used_slots++;
                    r.add_ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // runs of forty items with no gaps, then two runs with random gaps
    function automatic int sender_gap(input int idx);
        if ((idx / 40) % 3 == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input int dispatch_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return MODE_ADD;
        if (r < 10)
            return MODE_UNUSED;
        if (r < 10 + dispatch_pct)
            return MODE_DISPATCH;
        return MODE_TICK;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [IVAL_W-1:0] v,
                             input logic typed, input sched_result_t typed_res);
        sched_result_t predicted;
        int            gap;
        gap = sender_gap(items_sent);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        interval_value <= v;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        predicted = sched_step(m, v);
        expected_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // result side: random stalls, one long hold-off, compare with oldest expectation
    initial
    begin
        sched_result_t got;
        sched_result_t want;
        int            hold;
        out_ready = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (results_seen == 120)
                hold = 80;
            else if ((results_seen / 50) % 3 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            got = '{grant_valid, grant_index, add_ok};
            @(posedge clk);
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, got gv=%0d gi=%0d ok=%0d",
                         $time, got.grant_valid, got.grant_index, got.add_ok);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.grant_valid !== want.grant_valid)
                begin
                    $display("%0t: grant_valid expected %0d got %0d",
                             $time, want.grant_valid, got.grant_valid);
                    err_count++;
                end
                if (got.grant_index !== want.grant_index)
                begin
                    $display("%0t: grant_index expected %0d got %0d",
                             $time, want.grant_index, got.grant_index);
                    err_count++;
                end
                if (got.add_ok !== want.add_ok)
                begin
                    $display("%0t: add_ok expected %0d got %0d",
                             $time, want.add_ok, got.add_ok);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int i;
        int settle;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_TICK;
        interval_value = '0;
        err_count      = 0;
        items_sent     = 0;
        used_slots     = 0;
        for (i = 0; i < TASK_SLOTS; i++)
        begin
            reload_q[i]  = '0;
            count_q[i]   = '0;
            pending_q[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].mode, DIRECTED[i].ival, DIRECTED[i].typed,
                      DIRECTED[i].res);

        // sender holds back until the table has answered everything
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);

        // mostly dispatches, so pending runs drain and grants spread over the table
        for (i = 0; i < 200; i++)
            send_item(pick_mode(70), IVAL_W'($urandom), 1'b0, R_ZERO);

        // unbroken ticks drive the fastest tasks into pending saturation
        for (i = 0; i < 260; i++)
            send_item(MODE_TICK, IVAL_W'($urandom), 1'b0, R_ZERO);

        for (i = 0; i < 200; i++)
            send_item(pick_mode(80), IVAL_W'($urandom), 1'b0, R_ZERO);

        in_valid <= 1'b0;
        settle = 0;
        while (expected_results.size() != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (4) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
